>>> hw/rtl/lcl_pkg.sv
// Shared types and codes for the Li-Chao line hull block.
// Holds the controller-to-datapath command and status structs and the state encoding.
// No dependencies.
`timescale 1ns / 1ps

package lcl_pkg;

  localparam int TAG_W = 17;

  localparam logic [2:0] ACT_LOAD     = 3'd0;
  localparam logic [2:0] ACT_INS_LINE = 3'd1;
  localparam logic [2:0] ACT_INS_SEG  = 3'd2;
  localparam logic [2:0] ACT_QUERY    = 3'd3;
  localparam logic [2:0] ACT_CLEAR    = 3'd4;

  localparam logic CFG_KEEP_MAX = 1'b0;
  localparam logic CFG_EMPTY    = 1'b1;

  typedef enum logic [2:0] {
    CRD_L, CRD_RM1, CRD_MID, CRD_LOC_MID, CRD_LOC_LO
  } crd_src_t;

  typedef enum logic [2:0] {
    EV_LNL, EV_CURL, EV_LNR, EV_CURR, EV_LNM, EV_CURM, EV_Q
  } ev_dst_t;

  typedef enum logic [1:0] {
    RES_PLAIN, RES_NOTFOUND, RES_QUERY
  } res_kind_t;

  typedef enum logic [1:0] {
    CLS_DISJ, CLS_COVER, CLS_PART
  } cls_t;

  typedef enum logic [4:0] {
    ST_RST_CLR, ST_IDLE, ST_DISPATCH,
    ST_LOC, ST_LOC_WAIT, ST_LOC_FIN, ST_LOC_DONE,
    ST_VISIT, ST_POP,
    ST_INS_RD, ST_INS_A, ST_INS_B, ST_INS_C, ST_INS_D, ST_INS_E, ST_INS_F, ST_INS_G,
    ST_INS_DECIDE,
    ST_Q_RD, ST_Q_LATCH, ST_Q_EVAL, ST_Q_WAIT, ST_Q_STEP, ST_Q_DONE,
    ST_CLR
  } state_t;

  typedef struct packed {
    logic      latch;
    logic      load;
    logic      loc_init;
    logic      loc_sel;
    logic      loc_cmp;
    logic      loc_chk;
    logic      root;
    logic      root_full;
    logic      visit;
    logic      pop;
    logic      node_rd;
    logic      latch_cur;
    logic      put_new;
    logic      decide;
    logic      q_init;
    logic      q_step;
    logic      clr_init;
    logic      clr_step;
    logic      crd_en;
    crd_src_t  crd_src;
    logic      ev_en;
    logic      ev_cur;
    ev_dst_t   ev_dst;
    logic      emit;
    res_kind_t res_kind;
  } lcl_cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       loc_run;
    logic       loc_in;
    logic       loc_ok;
    logic       loc_second;
    cls_t       cls;
    logic       stack_empty;
    logic       node_valid;
    logic       ins_finish;
    logic       q_last;
    logic       clr_last;
  } lcl_stat_t;

endpackage

>>> hw/rtl/lcl_ctrl.sv
// Sequencing controller for the Li-Chao line hull block.
// Walks locate, insert, query and clear sequences; depends on lcl_pkg.
`timescale 1ns / 1ps

module lcl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  lcl_pkg::lcl_stat_t stat,
  output lcl_pkg::lcl_cmd_t  cmd,
  output logic              busy
);
  import lcl_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RST_CLR:  if (stat.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:     if (start) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (stat.act)
          ACT_INS_LINE:         state_nxt = ST_VISIT;
          ACT_INS_SEG, ACT_QUERY: state_nxt = ST_LOC;
          ACT_CLEAR:            state_nxt = ST_CLR;
          default:              state_nxt = ST_IDLE;
        endcase
      end
      ST_LOC: begin
        priority if (stat.loc_run) state_nxt = ST_LOC_WAIT;
        else if (stat.loc_in)      state_nxt = ST_LOC_FIN;
        else                       state_nxt = ST_LOC_DONE;
      end
      ST_LOC_WAIT: state_nxt = ST_LOC;
      ST_LOC_FIN:  state_nxt = ST_LOC_DONE;
      ST_LOC_DONE: begin
        priority if (!stat.loc_ok)       state_nxt = ST_IDLE;
        else if (stat.act == ACT_QUERY)  state_nxt = ST_Q_RD;
        else if (!stat.loc_second)       state_nxt = ST_LOC;
        else                             state_nxt = ST_VISIT;
      end
      ST_VISIT: begin
        unique case (stat.cls)
          CLS_DISJ:  state_nxt = ST_POP;
          CLS_COVER: state_nxt = ST_INS_RD;
          default:   state_nxt = ST_VISIT;
        endcase
      end
      ST_POP:        state_nxt = stat.stack_empty ? ST_IDLE : ST_VISIT;
      ST_INS_RD:     state_nxt = ST_INS_A;
      ST_INS_A:      state_nxt = stat.node_valid ? ST_INS_B : ST_POP;
      ST_INS_B:      state_nxt = ST_INS_C;
      ST_INS_C:      state_nxt = ST_INS_D;
      ST_INS_D:      state_nxt = ST_INS_E;
      ST_INS_E:      state_nxt = ST_INS_F;
      ST_INS_F:      state_nxt = ST_INS_G;
      ST_INS_G:      state_nxt = ST_INS_DECIDE;
      ST_INS_DECIDE: state_nxt = stat.ins_finish ? ST_POP : ST_INS_RD;
      ST_Q_RD:       state_nxt = ST_Q_LATCH;
      ST_Q_LATCH:    state_nxt = ST_Q_EVAL;
      ST_Q_EVAL:     state_nxt = ST_Q_WAIT;
      ST_Q_WAIT:     state_nxt = ST_Q_STEP;
      ST_Q_STEP:     state_nxt = stat.q_last ? ST_Q_DONE : ST_Q_RD;
      ST_Q_DONE:     state_nxt = ST_IDLE;
      ST_CLR:        if (stat.clr_last) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_RST_CLR: cmd.clr_step = 1'b1;
      ST_IDLE:    cmd.latch = start;
      ST_DISPATCH: begin
        unique case (stat.act)
          ACT_LOAD: begin
            cmd.load = 1'b1;
            cmd.emit = 1'b1;
          end
          ACT_INS_LINE: begin
            cmd.root      = 1'b1;
            cmd.root_full = 1'b1;
          end
          ACT_INS_SEG, ACT_QUERY: cmd.loc_init = 1'b1;
          ACT_CLEAR: cmd.clr_init = 1'b1;
          default:   cmd.emit = 1'b1;
        endcase
      end
      ST_LOC: begin
        priority if (stat.loc_run) begin
          cmd.crd_en  = 1'b1;
          cmd.crd_src = CRD_LOC_MID;
        end else if (stat.loc_in) begin
          cmd.crd_en  = 1'b1;
          cmd.crd_src = CRD_LOC_LO;
        end else begin
          cmd.loc_chk = 1'b1;
        end
      end
      ST_LOC_WAIT: cmd.loc_cmp = 1'b1;
      ST_LOC_FIN:  cmd.loc_chk = 1'b1;
      ST_LOC_DONE: begin
        priority if (!stat.loc_ok) begin
          cmd.emit     = 1'b1;
          cmd.res_kind = RES_NOTFOUND;
        end else if (stat.act == ACT_QUERY) begin
          cmd.q_init  = 1'b1;
          cmd.crd_en  = 1'b1;
          cmd.crd_src = CRD_LOC_LO;
        end else if (!stat.loc_second) begin
          cmd.loc_init = 1'b1;
          cmd.loc_sel  = 1'b1;
        end else begin
          cmd.root = 1'b1;
        end
      end
      ST_VISIT: cmd.visit = (stat.cls == CLS_PART);
      ST_POP: begin
        cmd.pop  = !stat.stack_empty;
        cmd.emit = stat.stack_empty;
      end
      ST_INS_RD: begin
        cmd.node_rd = 1'b1;
        cmd.crd_en  = 1'b1;
        cmd.crd_src = CRD_L;
      end
      ST_INS_A: begin
        cmd.latch_cur = 1'b1;
        cmd.put_new   = !stat.node_valid;
        cmd.ev_en     = stat.node_valid;
        cmd.ev_dst    = EV_LNL;
      end
      ST_INS_B: begin
        cmd.ev_en   = 1'b1;
        cmd.ev_cur  = 1'b1;
        cmd.ev_dst  = EV_CURL;
        cmd.crd_en  = 1'b1;
        cmd.crd_src = CRD_RM1;
      end
      ST_INS_C: begin
        cmd.ev_en  = 1'b1;
        cmd.ev_dst = EV_LNR;
      end
      ST_INS_D: begin
        cmd.ev_en   = 1'b1;
        cmd.ev_cur  = 1'b1;
        cmd.ev_dst  = EV_CURR;
        cmd.crd_en  = 1'b1;
        cmd.crd_src = CRD_MID;
      end
      ST_INS_E: begin
        cmd.ev_en  = 1'b1;
        cmd.ev_dst = EV_LNM;
      end
      ST_INS_F: begin
        cmd.ev_en  = 1'b1;
        cmd.ev_cur = 1'b1;
        cmd.ev_dst = EV_CURM;
      end
      ST_INS_G:      cmd.ev_en = 1'b0;
      ST_INS_DECIDE: cmd.decide = 1'b1;
      ST_Q_RD:       cmd.node_rd = 1'b1;
      ST_Q_LATCH:    cmd.latch_cur = 1'b1;
      ST_Q_EVAL: begin
        cmd.ev_en  = 1'b1;
        cmd.ev_cur = 1'b1;
        cmd.ev_dst = EV_Q;
      end
      ST_Q_WAIT: cmd.ev_en = 1'b0;
      ST_Q_STEP: cmd.q_step = 1'b1;
      ST_Q_DONE: begin
        cmd.emit     = 1'b1;
        cmd.res_kind = RES_QUERY;
      end
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        cmd.emit     = stat.clr_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> hw/rtl/lcl_datapath.sv
// Datapath of the Li-Chao line hull block: coordinate table, node memory,
// traversal registers with a frame stack, line evaluator and result registers.
// Depends on lcl_pkg.
`timescale 1ns / 1ps

module lcl_datapath #(
  parameter int NUM_POINTS = 1024,
  parameter int COORD_BITS = 32,
  parameter int COEF_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcl_pkg::lcl_cmd_t    cmd,
  output lcl_pkg::lcl_stat_t   stat,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [63:0]          cfg_wdata,
  input  logic [2:0]           in_action,
  input  logic [9:0]           in_coord_index,
  input  logic signed [31:0]   in_x_value,
  input  logic signed [31:0]   in_x_end,
  input  logic signed [31:0]   in_slope,
  input  logic signed [31:0]   in_intercept,
  input  logic signed [16:0]   in_line_tag,
  output logic                 out_valid,
  output logic                 out_status,
  output logic signed [63:0]   out_best_value,
  output logic signed [16:0]   out_best_tag,
  output logic                 out_found
);
  import lcl_pkg::*;

  localparam int AW    = $clog2(NUM_POINTS);
  localparam int LW    = AW + 1;
  localparam int NODES = 4 * NUM_POINTS;
  localparam int KW    = $clog2(NODES);
  localparam int SD    = AW + 1;
  localparam int SPW   = $clog2(SD + 1);
  localparam int IW    = $clog2(SD);
  localparam int PW    = COEF_BITS + COORD_BITS;
  localparam int ROW   = 1 + 2 * COEF_BITS + TAG_W;

  function automatic logic better(input logic km, input logic signed [63:0] inc,
                                  input logic signed [63:0] cand);
    return km ? (cand > inc) : (cand < inc);
  endfunction

  // Configuration
  logic               keep_max_r;
  logic signed [63:0] empty_r;

  // Latched item
  logic [2:0]                   act_r;
  logic [9:0]                   cidx_r;
  logic signed [COORD_BITS-1:0] xa_r, xb_r;
  logic signed [COEF_BITS-1:0]  ln_s_r, ln_b_r;
  logic [TAG_W-1:0]             ln_tag_r;

  // Line as it was given, kept for every covered subtree of a segment
  logic signed [COEF_BITS-1:0]  src_s_r, src_b_r;
  logic [TAG_W-1:0]             src_tag_r;

  // Line held in the node under work
  logic                         cur_v_r;
  logic signed [COEF_BITS-1:0]  cur_s_r, cur_b_r;
  logic [TAG_W-1:0]             cur_tag_r;

  // Memories
  logic [COORD_BITS-1:0]        coord_mem [NUM_POINTS];
  logic signed [COORD_BITS-1:0] coord_rd_r;
  logic [ROW-1:0]               node_mem [NODES];
  logic [ROW-1:0]               node_rd_r;

  // Binary search
  logic [LW-1:0] lo_r, hi_r, t1_r, t2e_r;
  logic          loc_sel_r, loc_ok_r;

  // Traversal frame and stack
  logic [LW-1:0]  l_r, r_r;
  logic [KW-1:0]  k_r;
  logic [LW-1:0]  stk_l [SD];
  logic [LW-1:0]  stk_r [SD];
  logic [KW-1:0]  stk_k [SD];
  logic [SPW-1:0] sp_r;

  // Evaluator
  logic signed [PW-1:0]        prod_r;
  logic signed [COEF_BITS-1:0] ev_b_r;
  ev_dst_t                     ev_dst_r;
  logic                        ev_v_r;
  logic signed [63:0]          e_lnl_r, e_curl_r, e_lnr_r, e_curr_r, e_lnm_r, e_curm_r, e_q_r;

  // Query result
  logic signed [63:0] best_r;
  logic [TAG_W-1:0]   best_tag_r;
  logic               found_r;

  logic [KW-1:0] clr_cnt_r;

  logic               out_valid_r, out_status_r, out_found_r;
  logic signed [63:0] out_value_r;
  logic [TAG_W-1:0]   out_tag_r;

  // Combinational helpers
  logic [LW:0]                  frame_sum, loc_sum;
  logic [LW-1:0]                mid, loc_mid, rm1, span;
  logic [KW-1:0]                child_l, child_r;
  logic signed [COORD_BITS-1:0] xs;
  logic [AW-1:0]                crd_addr;
  logic                         nrd_valid;
  logic signed [COEF_BITS-1:0]  nrd_s, nrd_b;
  logic [TAG_W-1:0]             nrd_tag;
  logic                         c_at_l, c_at_r, n_at_l, n_at_r, swap;
  logic                         cur_both, ln_both, leaf, finish, go_left;
  logic                         node_we;
  logic [KW-1:0]                node_waddr;
  logic [ROW-1:0]               node_wdata;
  logic [IW-1:0]                push_idx, pop_idx;
  logic signed [COEF_BITS-1:0]  mul_a;
  logic signed [63:0]           ev_sum;

  assign frame_sum = {1'b0, l_r} + {1'b0, r_r};
  assign mid       = frame_sum[LW:1];
  assign loc_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign loc_mid   = loc_sum[LW:1];
  assign rm1       = r_r - LW'(1);
  assign span      = r_r - l_r;
  assign child_l   = {k_r[KW-2:0], 1'b1};
  assign child_r   = {k_r[KW-2:0], 1'b0} + KW'(2);
  assign xs        = loc_sel_r ? xb_r : xa_r;
  assign push_idx  = sp_r[IW-1:0];
  assign pop_idx   = IW'(sp_r - SPW'(1));

  assign nrd_valid = node_rd_r[ROW-1];
  assign nrd_s     = $signed(node_rd_r[TAG_W+2*COEF_BITS-1 -: COEF_BITS]);
  assign nrd_b     = $signed(node_rd_r[TAG_W+COEF_BITS-1 -: COEF_BITS]);
  assign nrd_tag   = node_rd_r[TAG_W-1:0];

  always_comb begin
    unique case (cmd.crd_src)
      CRD_L:       crd_addr = l_r[AW-1:0];
      CRD_RM1:     crd_addr = rm1[AW-1:0];
      CRD_MID:     crd_addr = mid[AW-1:0];
      CRD_LOC_MID: crd_addr = loc_mid[AW-1:0];
      CRD_LOC_LO:  crd_addr = lo_r[AW-1:0];
      default:     crd_addr = '0;
    endcase
  end

  // Line comparison at the ends and the middle of the node's range.
  assign c_at_l   = better(keep_max_r, e_lnl_r, e_curl_r);
  assign c_at_r   = better(keep_max_r, e_lnr_r, e_curr_r);
  assign n_at_l   = better(keep_max_r, e_curl_r, e_lnl_r);
  assign n_at_r   = better(keep_max_r, e_curr_r, e_lnr_r);
  assign swap     = better(keep_max_r, e_curm_r, e_lnm_r);
  assign cur_both = c_at_l && c_at_r;
  assign ln_both  = n_at_l && n_at_r;
  assign leaf     = (span == LW'(1));
  assign finish   = cur_both || ln_both || leaf;
  // After a swap the carried line is the old stored one.
  assign go_left  = swap ? c_at_l : n_at_l;

  assign node_we    = cmd.clr_step || cmd.put_new ||
                      (cmd.decide && !cur_both && ln_both) ||
                      (cmd.decide && !finish && swap);
  assign node_waddr = cmd.clr_step ? clr_cnt_r : k_r;
  assign node_wdata = cmd.clr_step ? '0 : {1'b1, ln_s_r, ln_b_r, ln_tag_r};

  assign mul_a  = cmd.ev_cur ? cur_s_r : ln_s_r;
  assign ev_sum = 64'(prod_r) + 64'(ev_b_r);

  // Memories
  always_ff @(posedge clk) begin
    if (cmd.load && (32'(cidx_r) < NUM_POINTS)) begin
      coord_mem[AW'(cidx_r)] <= xa_r;
    end
    if (cmd.crd_en) begin
      coord_rd_r <= $signed(coord_mem[crd_addr]);
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (cmd.node_rd) begin
      node_rd_r <= node_mem[k_r];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_max_r  <= 1'b0;
      empty_r     <= 64'sh7FFF_FFFF_FFFF_FFFF;
      ev_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      clr_cnt_r   <= '0;
      sp_r        <= '0;
    end else begin
      if (cfg_we && (cfg_index == CFG_KEEP_MAX)) keep_max_r <= cfg_wdata[0];
      if (cfg_we && (cfg_index == CFG_EMPTY))    empty_r    <= $signed(cfg_wdata);
      ev_v_r      <= cmd.ev_en;
      out_valid_r <= cmd.emit;
      priority if (cmd.clr_init) clr_cnt_r <= '0;
      else if (cmd.clr_step)     clr_cnt_r <= clr_cnt_r + KW'(1);
      priority if (cmd.root) sp_r <= '0;
      else if (cmd.visit)    sp_r <= sp_r + SPW'(1);
      else if (cmd.pop)      sp_r <= sp_r - SPW'(1);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r     <= in_action;
      cidx_r    <= in_coord_index;
      xa_r      <= in_x_value[COORD_BITS-1:0];
      xb_r      <= in_x_end[COORD_BITS-1:0];
      ln_s_r    <= in_slope[COEF_BITS-1:0];
      ln_b_r    <= in_intercept[COEF_BITS-1:0];
      ln_tag_r  <= in_line_tag;
      src_s_r   <= in_slope[COEF_BITS-1:0];
      src_b_r   <= in_intercept[COEF_BITS-1:0];
      src_tag_r <= in_line_tag;
    end

    if (cmd.latch_cur) begin
      cur_v_r   <= nrd_valid;
      cur_s_r   <= nrd_s;
      cur_b_r   <= nrd_b;
      cur_tag_r <= nrd_tag;
    end

    if (cmd.loc_init) begin
      lo_r      <= '0;
      hi_r      <= LW'(NUM_POINTS);
      loc_sel_r <= cmd.loc_sel;
    end
    if (cmd.loc_cmp) begin
      if (coord_rd_r < xs) lo_r <= loc_mid + LW'(1);
      else                 hi_r <= loc_mid;
    end
    if (cmd.loc_chk) begin
      loc_ok_r <= (lo_r < LW'(NUM_POINTS)) && (coord_rd_r == xs);
      if (loc_sel_r) t2e_r <= lo_r + LW'(1);
      else           t1_r  <= lo_r;
    end

    if (cmd.root || cmd.q_init) begin
      l_r <= '0;
      r_r <= LW'(NUM_POINTS);
      k_r <= '0;
    end
    if (cmd.root && cmd.root_full) begin
      t1_r  <= '0;
      t2e_r <= LW'(NUM_POINTS);
    end
    if (cmd.visit) begin
      stk_l[push_idx] <= mid;
      stk_r[push_idx] <= r_r;
      stk_k[push_idx] <= child_r;
      r_r <= mid;
      k_r <= child_l;
    end
    if (cmd.pop) begin
      l_r      <= stk_l[pop_idx];
      r_r      <= stk_r[pop_idx];
      k_r      <= stk_k[pop_idx];
      ln_s_r   <= src_s_r;
      ln_b_r   <= src_b_r;
      ln_tag_r <= src_tag_r;
    end
    if (cmd.decide && !finish) begin
      if (swap) begin
        ln_s_r   <= cur_s_r;
        ln_b_r   <= cur_b_r;
        ln_tag_r <= cur_tag_r;
      end
      if (go_left) begin
        r_r <= mid;
        k_r <= child_l;
      end else begin
        l_r <= mid;
        k_r <= child_r;
      end
    end

    if (cmd.ev_en) begin
      prod_r   <= mul_a * coord_rd_r;
      ev_b_r   <= cmd.ev_cur ? cur_b_r : ln_b_r;
      ev_dst_r <= cmd.ev_dst;
    end
    if (ev_v_r) begin
      unique case (ev_dst_r)
        EV_LNL:  e_lnl_r  <= ev_sum;
        EV_CURL: e_curl_r <= ev_sum;
        EV_LNR:  e_lnr_r  <= ev_sum;
        EV_CURR: e_curr_r <= ev_sum;
        EV_LNM:  e_lnm_r  <= ev_sum;
        EV_CURM: e_curm_r <= ev_sum;
        default: e_q_r    <= ev_sum;
      endcase
    end

    if (cmd.q_init) begin
      best_r     <= empty_r;
      best_tag_r <= '1;
      found_r    <= 1'b0;
    end
    if (cmd.q_step) begin
      if (cur_v_r && better(keep_max_r, best_r, e_q_r)) begin
        best_r     <= e_q_r;
        best_tag_r <= cur_tag_r;
        found_r    <= 1'b1;
      end
      if (!(span <= LW'(1))) begin
        if (lo_r < mid) begin
          r_r <= mid;
          k_r <= child_l;
        end else begin
          l_r <= mid;
          k_r <= child_r;
        end
      end
    end

    if (cmd.emit) begin
      unique case (cmd.res_kind)
        RES_NOTFOUND: begin
          out_status_r <= 1'b1;
          out_value_r  <= empty_r;
          out_tag_r    <= '1;
          out_found_r  <= 1'b0;
        end
        RES_QUERY: begin
          out_status_r <= 1'b0;
          out_value_r  <= best_r;
          out_tag_r    <= best_tag_r;
          out_found_r  <= found_r;
        end
        default: begin
          out_status_r <= 1'b0;
          out_value_r  <= '0;
          out_tag_r    <= '1;
          out_found_r  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    stat             = '0;
    stat.act         = act_r;
    stat.loc_run     = (lo_r < hi_r);
    stat.loc_in      = (lo_r < LW'(NUM_POINTS));
    stat.loc_ok      = loc_ok_r;
    stat.loc_second  = loc_sel_r;
    priority if ((t2e_r <= l_r) || (r_r <= t1_r)) stat.cls = CLS_DISJ;
    else if ((t1_r <= l_r) && (r_r <= t2e_r))     stat.cls = CLS_COVER;
    else                                          stat.cls = CLS_PART;
    stat.stack_empty = (sp_r == '0);
    stat.node_valid  = nrd_valid;
    stat.ins_finish  = finish;
    stat.q_last      = (span <= LW'(1));
    stat.clr_last    = (clr_cnt_r == KW'(NODES - 1));
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_best_value = out_value_r;
  assign out_best_tag   = $signed(out_tag_r);
  assign out_found      = out_found_r;

endmodule

>>> hw/rtl/li_chao_line_hull.sv
// Top level of the Li-Chao line hull block: controller plus datapath.
// Depends on lcl_pkg, lcl_ctrl and lcl_datapath.
//
// Channel   Handshake              Payload
// input     start && !busy         in_action, in_coord_index, in_x_value, in_x_end,
//                                  in_slope, in_intercept, in_line_tag
// result    out_valid, one cycle   out_status, out_best_value, out_best_tag, out_found
// config    cfg_we                 cfg_index, cfg_wdata
//
// One item at a time. A coordinate lookup is a binary search through the one
// coordinate port. A query then evaluates one node per tree level from the root; an
// insert evaluates six line values per node it descends on the single multiplier.
// Clear tree and reset both sweep all 4*NUM_POINTS node entries, with busy high.
// The receiver cannot stall: a result shows for one cycle while the next item may
// already be accepted.
`timescale 1ns / 1ps

module li_chao_line_hull #(
  parameter int NUM_POINTS = 1024,
  parameter int COORD_BITS = 32,
  parameter int COEF_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_action,
  input  logic [9:0]         in_coord_index,
  input  logic signed [31:0] in_x_value,
  input  logic signed [31:0] in_x_end,
  input  logic signed [31:0] in_slope,
  input  logic signed [31:0] in_intercept,
  input  logic signed [16:0] in_line_tag,
  output logic               out_valid,
  output logic               out_status,
  output logic signed [63:0] out_best_value,
  output logic signed [16:0] out_best_tag,
  output logic               out_found,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_wdata
);
  import lcl_pkg::*;

  lcl_cmd_t  cmd;
  lcl_stat_t stat;

  lcl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  lcl_datapath #(
    .NUM_POINTS (NUM_POINTS),
    .COORD_BITS (COORD_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_action      (in_action),
    .in_coord_index (in_coord_index),
    .in_x_value     (in_x_value),
    .in_x_end       (in_x_end),
    .in_slope       (in_slope),
    .in_intercept   (in_intercept),
    .in_line_tag    (in_line_tag),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_best_value (out_best_value),
    .out_best_tag   (out_best_tag),
    .out_found      (out_found)
  );

  // An accepted transfer always keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised after transfer");

  // Every item returns to idle after its result, so results never come back to back.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("results on consecutive cycles");

  // A missing coordinate never reports a found line.
  a_nf_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> !out_found) else $error("not-found with found set");

  // Without a found line the tag is the no-tag value.
  a_tag_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_best_tag == -17'sd1))
    else $error("tag set without a found line");

endmodule
